### hdl/mlr_pkg.sv
package mlr_pkg;

	localparam int COORD_BITS_DEF  = 6;
	localparam int COLOUR_W        = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

endpackage

### hdl/midpoint_line_rasterizer_unit.sv
// Midpoint line rasterizer: each command beat (start, end, colour) yields one pixel beat per
// step along the major axis, from the start point up to but not including the end point; a
// zero-length line yields nothing and the final pixel carries last_pixel. The walker produces
// one pixel per cycle unless out_ready stalls it; a line has at most 63 pixels at the default
// tile size, and the next queued line follows without a gap. Commands are classified one per
// cycle in the front end while the queue has room and wait in a two-entry queue, so new
// commands are taken while a line is still being drawn.
module midpoint_line_rasterizer_unit #(
	parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COORD_BITS-1:0]        x_start,
	input  logic [COORD_BITS-1:0]        y_start,
	input  logic [COORD_BITS-1:0]        x_end,
	input  logic [COORD_BITS-1:0]        y_end,
	input  logic [mlr_pkg::COLOUR_W-1:0] pixel_colour,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic [mlr_pkg::COLOUR_W-1:0] colour_out,
	output logic                         last_pixel
);

	localparam int CMD_W = 3 * COORD_BITS + 3 + COORD_BITS + mlr_pkg::COLOUR_W;

	logic             f_valid;
	logic             f_ready;
	logic [CMD_W-1:0] f_data;
	logic             b_valid;
	logic             b_ready;
	logic [CMD_W-1:0] b_data;

	mlr_front #(
		.COORD_BITS(COORD_BITS),
		.CMD_W     (CMD_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.pixel_colour(pixel_colour),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd_data    (f_data)
	);

	mlr_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	mlr_walker #(
		.COORD_BITS(COORD_BITS),
		.CMD_W     (CMD_W)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_data  (b_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.colour_out(colour_out),
		.last_pixel(last_pixel)
	);

endmodule

### hdl/mlr_queue.sv
module mlr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/mlr_front.sv
module mlr_front #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
	parameter int CMD_W      = 3 * COORD_BITS + 3 + COORD_BITS + mlr_pkg::COLOUR_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COORD_BITS-1:0]        x_start,
	input  logic [COORD_BITS-1:0]        y_start,
	input  logic [COORD_BITS-1:0]        x_end,
	input  logic [COORD_BITS-1:0]        y_end,
	input  logic [mlr_pkg::COLOUR_W-1:0] pixel_colour,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output logic [CMD_W-1:0]             cmd_data
);

	typedef struct packed {
		logic                         x_major;
		logic                         maj_up;
		logic                         mnr_up;
		logic [COORD_BITS-1:0]        dmaj;
		logic [COORD_BITS-1:0]        dmin;
		logic [COORD_BITS-1:0]        maj;
		logic [COORD_BITS-1:0]        mnr;
		logic [mlr_pkg::COLOUR_W-1:0] colour;
	} cmd_t;

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	cmd_t                  cmd;
	cmd_t                  cmd_s1;
	logic                  valid_s1;
	logic                  accept;

	always_comb begin
		adx = (x_start > x_end) ? x_start - x_end : x_end - x_start;
		ady = (y_start > y_end) ? y_start - y_end : y_end - y_start;
		cmd.x_major = (adx > ady);
		cmd.dmaj    = cmd.x_major ? adx : ady;
		cmd.dmin    = cmd.x_major ? ady : adx;
		cmd.maj     = cmd.x_major ? x_start : y_start;
		cmd.mnr     = cmd.x_major ? y_start : x_start;
		cmd.maj_up  = cmd.x_major ? (x_end > x_start) : (y_end > y_start);
		cmd.mnr_up  = cmd.x_major ? (y_end > y_start) : (x_end > x_start);
		cmd.colour  = pixel_colour;
	end

	// Zero-length lines are taken and dropped here.
	assign in_ready  = !valid_s1 || cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && (cmd.dmaj != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

### hdl/mlr_walker.sv
module mlr_walker #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
	parameter int CMD_W      = 3 * COORD_BITS + 3 + COORD_BITS + mlr_pkg::COLOUR_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [CMD_W-1:0]             cmd_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic [mlr_pkg::COLOUR_W-1:0] colour_out,
	output logic                         last_pixel
);

	localparam int ERR_W = COORD_BITS + 3;

	typedef struct packed {
		logic                         x_major;
		logic                         maj_up;
		logic                         mnr_up;
		logic [COORD_BITS-1:0]        dmaj;
		logic [COORD_BITS-1:0]        dmin;
		logic [COORD_BITS-1:0]        maj;
		logic [COORD_BITS-1:0]        mnr;
		logic [mlr_pkg::COLOUR_W-1:0] colour;
	} cmd_t;

	cmd_t                     in_cmd;
	cmd_t                     cur_q;
	logic [COORD_BITS-1:0]    rem_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  err_sum;
	logic signed [ERR_W-1:0]  dmaj_ext;
	logic signed [ERR_W-1:0]  dmaj2_ext;
	logic signed [ERR_W-1:0]  dmin2_ext;
	logic                     busy_q;
	logic                     out_valid_q;
	logic                     adv;
	logic                     is_last;
	logic                     load;
	logic                     mnr_step;

	assign in_cmd = cmd_t'(cmd_data);

	always_comb begin
		dmaj_ext  = {3'b000, cur_q.dmaj};
		dmaj2_ext = {2'b00, cur_q.dmaj, 1'b0};
		dmin2_ext = {2'b00, cur_q.dmin, 1'b0};
		err_sum   = err_q + dmin2_ext;
		mnr_step  = (err_sum >= dmaj_ext);
		adv       = busy_q && (!out_valid_q || out_ready);
		is_last   = (rem_q == COORD_BITS'(1));
		load      = cmd_valid && (!busy_q || (adv && is_last));
	end

	assign cmd_ready = load;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_x    <= cur_q.x_major ? cur_q.maj : cur_q.mnr;
			pixel_y    <= cur_q.x_major ? cur_q.mnr : cur_q.maj;
			colour_out <= cur_q.colour;
			last_pixel <= is_last;
		end
		if (load) begin
			cur_q <= in_cmd;
			rem_q <= in_cmd.dmaj;
			err_q <= '0;
		end else if (adv) begin
			rem_q     <= rem_q - 1'b1;
			cur_q.maj <= cur_q.maj_up ? cur_q.maj + 1'b1 : cur_q.maj - 1'b1;
			if (mnr_step) begin
				cur_q.mnr <= cur_q.mnr_up ? cur_q.mnr + 1'b1 : cur_q.mnr - 1'b1;
				err_q     <= err_sum - dmaj2_ext;
			end else begin
				err_q <= err_sum;
			end
		end
	end

endmodule

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = mlr_pkg::COORD_BITS_DEF;
	localparam int CW = mlr_pkg::COLOUR_W;

	typedef struct packed {
		logic [CB-1:0] xs;
		logic [CB-1:0] ys;
		logic [CB-1:0] xe;
		logic [CB-1:0] ye;
		logic [CW-1:0] colour;
	} line_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CW-1:0] colour;
		logic          last;
	} pixel_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [CB-1:0] x_start = '0;
	logic [CB-1:0] y_start = '0;
	logic [CB-1:0] x_end = '0;
	logic [CB-1:0] y_end = '0;
	logic [CW-1:0] pixel_colour = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CB-1:0] pixel_x;
	logic [CB-1:0] pixel_y;
	logic [CW-1:0] colour_out;
	logic          last_pixel;

	pixel_t pending_pixels[$];
	int     error_count = 0;
	bit     idle_on = 1'b1;
	int     stall_left = 0;

	midpoint_line_rasterizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_colour(pixel_colour),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.colour_out(colour_out),
		.last_pixel(last_pixel)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_error(input string msg);
		if (error_count < 100)
			$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void plot_line(input line_t l);
		int            adx;
		int            ady;
		int            dmaj;
		int            dmin;
		int            err;
		bit            x_major;
		bit            maj_up;
		bit            mnr_up;
		logic [CB-1:0] maj;
		logic [CB-1:0] mnr;
		pixel_t        p;
		adx = (l.xs > l.xe) ? int'(l.xs) - int'(l.xe) : int'(l.xe) - int'(l.xs);
		ady = (l.ys > l.ye) ? int'(l.ys) - int'(l.ye) : int'(l.ye) - int'(l.ys);
		x_major = adx > ady;
		dmaj = x_major ? adx : ady;
		dmin = x_major ? ady : adx;
		maj = x_major ? l.xs : l.ys;
		mnr = x_major ? l.ys : l.xs;
		maj_up = x_major ? (l.xe > l.xs) : (l.ye > l.ys);
		mnr_up = x_major ? (l.ye > l.ys) : (l.xe > l.xs);
		err = 0;
		for (int k = 0; k < dmaj; k++) begin
			p.x = x_major ? maj : mnr;
			p.y = x_major ? mnr : maj;
			p.colour = l.colour;
			p.last = (k + 1 == dmaj);
			pending_pixels.push_back(p);
			err += 2 * dmin;
			if (err >= dmaj) begin
				mnr = mnr_up ? mnr + 1'b1 : mnr - 1'b1;
				err -= 2 * dmaj;
			end
			maj = maj_up ? maj + 1'b1 : maj - 1'b1;
		end
	endfunction

	task automatic send_line(input line_t l);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_start <= l.xs;
		y_start <= l.ys;
		x_end <= l.xe;
		y_end <= l.ye;
		pixel_colour <= l.colour;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		plot_line(l);
	endtask

	function automatic line_t make_line(input int xs, input int ys, input int xe, input int ye,
			input logic [CW-1:0] colour);
		line_t l;
		l.xs = CB'(xs);
		l.ys = CB'(ys);
		l.xe = CB'(xe);
		l.ye = CB'(ye);
		l.colour = colour;
		return l;
	endfunction

	function automatic line_t random_line();
		line_t l;
		int    len;
		l.xs = CB'($urandom);
		l.ys = CB'($urandom);
		l.xe = CB'($urandom);
		l.ye = CB'($urandom);
		l.colour = $urandom;
		case ($urandom_range(0, 9))
			0: begin
				l.xe = l.xs;
				l.ye = l.ys;
			end
			1: l.ye = l.ys;
			2: l.xe = l.xs;
			3: begin
				len = $urandom_range(0, 63);
				l.xs = CB'($urandom_range(0, 63 - len));
				l.ys = CB'($urandom_range(0, 63 - len));
				l.xe = CB'(int'(l.xs) + len);
				l.ye = CB'(int'(l.ys) + len);
				if ($urandom_range(0, 1)) begin
					l.xs = CB'(63 - int'(l.xs));
					l.xe = CB'(63 - int'(l.xe));
				end
			end
			4, 5: begin
				l.xe = CB'(int'(l.xs) + int'($urandom_range(0, 4)) - 2);
				l.ye = CB'(int'(l.ys) + int'($urandom_range(0, 4)) - 2);
				if ($urandom_range(0, 1)) begin
					l.xe = CB'(int'(l.xs) + int'($urandom_range(0, 6)) - 3);
					l.ye = CB'(int'(l.ys) + int'($urandom_range(0, 6)) - 3);
				end
				if ((l.xs > 59) || (l.xs < 4) || (l.ys > 59) || (l.ys < 4)) begin
					l.xe = l.xs;
					l.ye = CB'(int'(l.ys) + ((l.ys > 31) ? -1 : 1));
				end
			end
			default: ;
		endcase
		return l;
	endfunction

	always @(posedge clk) begin
		if (idle_on && stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : pixel_check
		pixel_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel beat x=%0d y=%0d", pixel_x, pixel_y));
			end else begin
				exp_px = pending_pixels.pop_front();
				if (pixel_x !== exp_px.x)
					flag_error($sformatf("pixel_x %0d, expected %0d", pixel_x, exp_px.x));
				if (pixel_y !== exp_px.y)
					flag_error($sformatf("pixel_y %0d, expected %0d", pixel_y, exp_px.y));
				if (colour_out !== exp_px.colour)
					flag_error($sformatf("colour_out %h, expected %h", colour_out,
						exp_px.colour));
				if (last_pixel !== exp_px.last)
					flag_error($sformatf("last_pixel %b, expected %b at x=%0d y=%0d",
						last_pixel, exp_px.last, exp_px.x, exp_px.y));
			end
		end
	end

	task automatic test_directed_lines();
		send_line(make_line(0, 0, 0, 0, 32'h0000_0000));
		send_line(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
		send_line(make_line(0, 0, 63, 0, 32'hFFFF_FFFF));
		send_line(make_line(63, 63, 0, 63, 32'h0000_0000));
		send_line(make_line(0, 0, 0, 63, 32'hA5A5_5A5A));
		send_line(make_line(63, 63, 63, 0, 32'h5A5A_A5A5));
		send_line(make_line(0, 0, 63, 63, 32'h1234_5678));
		send_line(make_line(63, 0, 0, 63, 32'h8765_4321));
		send_line(make_line(63, 63, 0, 0, 32'hDEAD_BEEF));
		send_line(make_line(0, 63, 63, 0, 32'hCAFE_F00D));
		send_line(make_line(10, 10, 11, 10, 32'h0000_0001));
		send_line(make_line(10, 10, 10, 9, 32'h8000_0000));
		send_line(make_line(10, 10, 11, 11, 32'h0F0F_0F0F));
		send_line(make_line(20, 20, 22, 21, 32'hF0F0_F0F0));
		send_line(make_line(20, 20, 18, 19, 32'h3333_3333));
		send_line(make_line(20, 20, 21, 22, 32'hCCCC_CCCC));
		send_line(make_line(20, 20, 19, 18, 32'h5555_5555));
		send_line(make_line(5, 40, 60, 30, 32'hAAAA_AAAA));
		send_line(make_line(60, 3, 1, 50, 32'h0123_4567));
		send_line(make_line(0, 0, 63, 1, 32'h89AB_CDEF));
		send_line(make_line(0, 63, 62, 0, 32'h7777_7777));
		send_line(make_line(32, 32, 32, 32, 32'h9999_9999));
	endtask

	task automatic test_random_lines();
		repeat (108) send_line(random_line());
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		repeat (30) send_line(random_line());
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		test_random_lines();
		test_steady_stream();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0 && pending_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### sim.f
hdl/mlr_pkg.sv
hdl/mlr_queue.sv
hdl/mlr_front.sv
hdl/mlr_walker.sv
hdl/midpoint_line_rasterizer_unit.sv
test/tb.sv
